[hdl/csd_pkg.sv]
// Shared types, constants and the glyph table of the sixteen-segment display controller.
`default_nettype none
package csd_pkg;

    localparam int NUM_DIGITS  = 5;
    localparam int BRIGHT_BITS = 6;
    localparam int BRIGHT_W    = 3;
    localparam int POS_W       = $clog2(NUM_DIGITS + 1);
    localparam int SIDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int DIG_W       = 3;
    localparam int GLYPH_W     = 17;
    localparam int TDATA_W     = 32;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] BYTE_LF      = 8'h0A;
    localparam logic [7:0] BYTE_CR      = 8'h0D;
    localparam logic [7:0] PRINT_FIRST  = 8'h20;
    localparam logic [7:0] DP_FIRST     = 8'hA0;
    localparam logic [7:0] DP_MASK      = 8'h02;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd5;

    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_BYTE   = 1'b1;
    localparam logic KIND_DRIVE = 1'b0;
    localparam logic KIND_FWD   = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_FWD,
        CMD_STORE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [7:0]          data;
        logic [SIDX_W-1:0]   pos;
        logic                lit;
        logic [GLYPH_W-1:0]  glyph;
    } csd_cmd_t;

    // Returns {D1, high byte, low byte} for a glyph index.
    function automatic logic [GLYPH_W-1:0] glyph_lookup(input logic [6:0] idx);
        logic [GLYPH_W-1:0] g;
        case (idx)
            7'd1:        g = 17'h0A4C0;
            7'd2:        g = 17'h05000;
            7'd3:        g = 17'h14C35;
            7'd4:        g = 17'h1DC95;
            7'd5:        g = 17'h03A5C;
            7'd6:        g = 17'h1A9CD;
            7'd7:        g = 17'h04000;
            7'd8:        g = 17'h00048;
            7'd9:        g = 17'h02200;
            7'd10:       g = 17'h06E58;
            7'd11:       g = 17'h04C10;
            7'd12:       g = 17'h00200;
            7'd13:       g = 17'h00810;
            7'd14:       g = 17'h00400;
            7'd15:       g = 17'h00240;
            7'd16:       g = 17'h193E5;
            7'd17:       g = 17'h00024;
            7'd18:       g = 17'h189B1;
            7'd19:       g = 17'h188B5;
            7'd20:       g = 17'h01834;
            7'd21:       g = 17'h19895;
            7'd22:       g = 17'h19995;
            7'd23:       g = 17'h090A4;
            7'd24:       g = 17'h199B5;
            7'd25:       g = 17'h198B5;
            7'd26:       g = 17'h04400;
            7'd27:       g = 17'h04200;
            7'd28:       g = 17'h10241;
            7'd29:       g = 17'h10811;
            7'd30:       g = 17'h12009;
            7'd31:       g = 17'h084B0;
            7'd32:       g = 17'h09525;
            7'd33, 7'd65: g = 17'h099B4;
            7'd34, 7'd66: g = 17'h199D5;
            7'd35, 7'd67: g = 17'h19181;
            7'd36, 7'd68: g = 17'h1C4A5;
            7'd37, 7'd69: g = 17'h19991;
            7'd38, 7'd70: g = 17'h09990;
            7'd39, 7'd71: g = 17'h19195;
            7'd40, 7'd72: g = 17'h01934;
            7'd41, 7'd73: g = 17'h1C481;
            7'd42, 7'd74: g = 17'h10125;
            7'd43, 7'd75: g = 17'h01948;
            7'd44, 7'd76: g = 17'h11101;
            7'd45, 7'd77: g = 17'h03164;
            7'd46, 7'd78: g = 17'h0312C;
            7'd47, 7'd79: g = 17'h191A5;
            7'd48, 7'd80: g = 17'h099B0;
            7'd49, 7'd81: g = 17'h191AD;
            7'd50, 7'd82: g = 17'h099B8;
            7'd51, 7'd83: g = 17'h1A095;
            7'd52, 7'd84: g = 17'h0C480;
            7'd53, 7'd85: g = 17'h11125;
            7'd54, 7'd86: g = 17'h01340;
            7'd55, 7'd87: g = 17'h0132C;
            7'd56, 7'd88: g = 17'h02248;
            7'd57, 7'd89: g = 17'h02440;
            7'd58, 7'd90: g = 17'h182C1;
            7'd59:       g = 17'h04481;
            7'd60:       g = 17'h02008;
            7'd61:       g = 17'h1C400;
            7'd62:       g = 17'h03000;
            7'd63:       g = 17'h10001;
            7'd64:       g = 17'h00040;
            7'd91:       g = 17'h04C81;
            7'd92:       g = 17'h01100;
            7'd93:       g = 17'h1C410;
            7'd94:       g = 17'h03030;
            7'd95:       g = 17'h0FFFF;
            7'd96:       g = 17'h04000;
            7'd97:       g = 17'h00040;
            7'd98:       g = 17'h00010;
            7'd99:       g = 17'h00008;
            7'd100:      g = 17'h00400;
            7'd101:      g = 17'h00200;
            7'd102:      g = 17'h00800;
            7'd103:      g = 17'h02000;
            default:     g = '0;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

[hdl/csd_front.sv]
// Front end: accepts requests, keeps the position, brightness and scan counters, issues commands.
`default_nettype none
module csd_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // rx_byte
    input  wire logic              s_tuser,   // action
    input  wire logic              q_full,
    output logic                   q_push,
    output csd_pkg::csd_cmd_t      q_cmd
);

    logic [csd_pkg::POS_W-1:0]       wp_reg, wp_next;
    logic [csd_pkg::BRIGHT_W-1:0]    bright_reg, bright_next;
    logic [csd_pkg::BRIGHT_BITS-1:0] pwm_reg, pwm_next;
    logic [csd_pkg::SIDX_W-1:0]      scan_reg, scan_next;

    logic                            accept;
    logic [6:0]                      glyph_idx;
    logic                            dp;
    logic [csd_pkg::GLYPH_W-1:0]     glyph;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        dp        = (s_tdata >= csd_pkg::DP_FIRST);
        glyph_idx = dp ? 7'(s_tdata - csd_pkg::DP_FIRST) : 7'(s_tdata - csd_pkg::PRINT_FIRST);
        glyph     = csd_pkg::glyph_lookup(glyph_idx);
        if (dp) begin
            glyph[7:0] = glyph[7:0] | csd_pkg::DP_MASK;
        end
    end

    always_comb begin
        wp_next     = wp_reg;
        bright_next = bright_reg;
        pwm_next    = pwm_reg;
        scan_next   = scan_reg;
        q_push      = 1'b0;
        q_cmd       = '0;
        q_cmd.kind  = csd_pkg::CMD_FWD;
        q_cmd.data  = s_tdata;
        if (accept) begin
            if (s_tuser == csd_pkg::ACT_TICK) begin
                q_push     = 1'b1;
                q_cmd.kind = csd_pkg::CMD_TICK;
                q_cmd.data = '0;
                q_cmd.pos  = scan_reg;
                q_cmd.lit  = ((pwm_reg >> bright_reg) == '0);
                pwm_next   = pwm_reg + 1'b1;
                if (pwm_reg == '1) begin
                    if (scan_reg == csd_pkg::SIDX_W'(csd_pkg::NUM_DIGITS - 1)) begin
                        scan_next = '0;
                    end else begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end else if (s_tdata >= 8'd1 && s_tdata <= 8'(csd_pkg::BRIGHT_BITS)) begin
                q_push      = 1'b1;
                bright_next = csd_pkg::BRIGHT_W'(s_tdata - 8'd1);
            end else if (s_tdata == csd_pkg::BYTE_LF || s_tdata == csd_pkg::BYTE_CR) begin
                q_push  = 1'b1;
                wp_next = '0;
            end else if (s_tdata >= csd_pkg::PRINT_FIRST) begin
                q_push = 1'b1;
                if (wp_reg < csd_pkg::POS_W'(csd_pkg::NUM_DIGITS)) begin
                    q_cmd.kind  = csd_pkg::CMD_STORE;
                    q_cmd.pos   = wp_reg[csd_pkg::SIDX_W-1:0];
                    q_cmd.glyph = glyph;
                    wp_next     = wp_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= '0;
            bright_reg <= csd_pkg::BRIGHT_RESET;
            pwm_reg    <= '0;
            scan_reg   <= '0;
        end else begin
            wp_reg     <= wp_next;
            bright_reg <= bright_next;
            pwm_reg    <= pwm_next;
            scan_reg   <= scan_next;
        end
    end

endmodule
`default_nettype wire

[hdl/csd_queue.sv]
// Short command queue between the front end and the back end.
`default_nettype none
module csd_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  csd_pkg::csd_cmd_t       push_cmd,
    input  wire logic               pop,
    output csd_pkg::csd_cmd_t       head,
    output logic                    head_valid,
    output logic                    full
);

    csd_pkg::csd_cmd_t                q_mem [csd_pkg::QDEPTH];
    logic [csd_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [csd_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [csd_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;

    assign head       = q_mem[rd_ptr_reg];
    assign head_valid = (cnt_reg != '0);
    assign full       = (cnt_reg == csd_pkg::QCNT_W'(csd_pkg::QDEPTH));

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + csd_pkg::QCNT_W'(push) - csd_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

[hdl/csd_back.sv]
// Back end: holds the segment store, carries out commands and drives the result register.
`default_nettype none
module csd_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  csd_pkg::csd_cmd_t                 head,
    input  wire logic                         head_valid,
    output logic                              pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [csd_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tuser
);

    logic [csd_pkg::GLYPH_W-1:0]  store_reg [csd_pkg::NUM_DIGITS];
    logic                         m_tvalid_reg, m_tvalid_next;
    logic                         m_tuser_reg, m_tuser_next;
    logic [csd_pkg::TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                         out_free;
    logic                         needs_out;
    logic [csd_pkg::GLYPH_W-1:0]  seg;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign needs_out = (head.kind == csd_pkg::CMD_TICK) || (head.kind == csd_pkg::CMD_FWD);
    assign pop       = head_valid && (!needs_out || out_free);
    assign seg       = head.lit ? store_reg[head.pos] : '0;

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        if (pop) begin
            case (head.kind)
                csd_pkg::CMD_TICK: begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = csd_pkg::KIND_DRIVE;
                    m_tdata_next  = {3'b000, seg[16], seg[15:8], seg[7:0],
                                     csd_pkg::DIG_W'(head.pos), head.lit, 8'h00};
                end
                csd_pkg::CMD_FWD: begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = csd_pkg::KIND_FWD;
                    m_tdata_next  = {24'h000000, head.data};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < csd_pkg::NUM_DIGITS; i++) begin
                store_reg[i] <= '0;
            end
        end else if (pop && head.kind == csd_pkg::CMD_STORE) begin
            store_reg[head.pos] <= head.glyph;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

[hdl/chained_sixteen_segment_display_ctrl.sv]
// Top level of the chained sixteen-segment display controller.
// The slave channel takes one request per cycle while the queue is not full: s_tuser
// low is a scan tick, s_tuser high carries a received byte in s_tdata. The master channel
// returns a drive result for every tick (m_tuser low) and a forwarded byte for brightness
// bytes, CR, LF and printable bytes that no longer fit (m_tuser high). Stored and ignored
// bytes give no result. The front end classifies a request in its cycle and writes a
// command into a four-entry queue; the back end executes the head command against the
// five-entry segment store and loads the output register. Throughput is one request per
// cycle while the queue is not full, set by the single command queue port on each side.
// When the receiver stalls, the output register holds, the queue fills and s_tready drops
// after four more commands; stored and ignored bytes do not need the output register.
// Synchronous reset clears the segment store to blank, the write position, PWM slot and
// scan digit to zero, sets brightness level five and empties the queue and output.
`default_nettype none
module chained_sixteen_segment_display_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,  // [7:0] rx_byte
    input  wire logic                          s_tuser,  // [0] action
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] forward_byte, [8] digit_lit, [11:9] digit_index, [19:12] segments_low,
    // [27:20] segments_high, [28] segment_d1, [31:29] zero
    output logic [csd_pkg::TDATA_W-1:0]        m_tdata,
    output logic                               m_tuser   // [0] result_kind
);

    csd_pkg::csd_cmd_t push_cmd;
    csd_pkg::csd_cmd_t head;
    logic              push;
    logic              pop;
    logic              head_valid;
    logic              full;

    csd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (full),
        .q_push   (push),
        .q_cmd    (push_cmd)
    );

    csd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    csd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

[hdl/csd_checker.sv]
// Port-level checker for the display controller and its bind to the top level.
`default_nettype none
module csd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [csd_pkg::TDATA_W-1:0]   m_tdata,
    input wire logic                          m_tuser
);

    // A stalled result must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Forwarded bytes carry no display drive.
    a_fwd_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:8] == 24'h000000)
        else $error("forward result carries display fields");

    // An unlit slot drives no segments and no byte.
    a_unlit_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && !m_tdata[8] |-> m_tdata[28:12] == '0 && m_tdata[7:0] == 8'h00)
        else $error("unlit slot drives segments");

    // The scanned digit is always one that exists.
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[11:9] < 3'(csd_pkg::NUM_DIGITS))
        else $error("digit index out of range");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind chained_sixteen_segment_display_ctrl csd_checker u_csd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

[sim/csd_tb_pkg.sv]
// Expected-output model and checker for the sixteen-segment display controller testbench.
`timescale 1ns / 1ps
package csd_tb_pkg;
    import csd_pkg::*;

    // Glyphs for bytes 0x20 to 0x9F, each {D1, high byte, low byte}.
    localparam logic [23:0] GLYPH_ROM [128] = '{
        24'h000000, 24'h00A4C0, 24'h005000, 24'h014C35,
        24'h01DC95, 24'h003A5C, 24'h01A9CD, 24'h004000,
        24'h000048, 24'h002200, 24'h006E58, 24'h004C10,
        24'h000200, 24'h000810, 24'h000400, 24'h000240,
        24'h0193E5, 24'h000024, 24'h0189B1, 24'h0188B5,
        24'h001834, 24'h019895, 24'h019995, 24'h0090A4,
        24'h0199B5, 24'h0198B5, 24'h004400, 24'h004200,
        24'h010241, 24'h010811, 24'h012009, 24'h0084B0,
        24'h009525, 24'h0099B4, 24'h0199D5, 24'h019181,
        24'h01C4A5, 24'h019991, 24'h009990, 24'h019195,
        24'h001934, 24'h01C481, 24'h010125, 24'h001948,
        24'h011101, 24'h003164, 24'h00312C, 24'h0191A5,
        24'h0099B0, 24'h0191AD, 24'h0099B8, 24'h01A095,
        24'h00C480, 24'h011125, 24'h001340, 24'h00132C,
        24'h002248, 24'h002440, 24'h0182C1, 24'h004481,
        24'h002008, 24'h01C400, 24'h003000, 24'h010001,
        24'h000040, 24'h0099B4, 24'h0199D5, 24'h019181,
        24'h01C4A5, 24'h019991, 24'h009990, 24'h019195,
        24'h001934, 24'h01C481, 24'h010125, 24'h001948,
        24'h011101, 24'h003164, 24'h00312C, 24'h0191A5,
        24'h0099B0, 24'h0191AD, 24'h0099B8, 24'h01A095,
        24'h00C480, 24'h011125, 24'h001340, 24'h00132C,
        24'h002248, 24'h002440, 24'h0182C1, 24'h004C81,
        24'h001100, 24'h01C410, 24'h003030, 24'h00FFFF,
        24'h004000, 24'h000040, 24'h000010, 24'h000008,
        24'h000400, 24'h000200, 24'h000800, 24'h002000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] fwd;
        logic       lit;
        logic [2:0] digit;
        logic [7:0] seg_lo;
        logic [7:0] seg_hi;
        logic       d1;
    } display_out_t;

    class display_drive_model;
        logic [16:0]  digit_glyph [NUM_DIGITS];
        int unsigned  write_pos;
        logic [2:0]   bright;
        int unsigned  slot;
        int unsigned  scan;
        display_out_t due_results [$];
        int errors;
        int n_accepted;
        int n_ticks;
        int n_lit;
        int n_stored;
        int n_forwarded;
        int n_ignored;
        int n_checked;
        logic [NUM_DIGITS-1:0] lit_digits;

        function new();
            foreach (digit_glyph[i]) digit_glyph[i] = '0;
            write_pos = 0;
            bright = BRIGHT_RESET;
            slot = 0;
            scan = 0;
            errors = 0;
            n_accepted = 0;
            n_ticks = 0;
            n_lit = 0;
            n_stored = 0;
            n_forwarded = 0;
            n_ignored = 0;
            n_checked = 0;
            lit_digits = '0;
        endfunction

        function logic [16:0] glyph_for(logic [7:0] b);
            logic [6:0]  idx;
            logic [16:0] g;
            if (b >= DP_FIRST) begin
                idx = 7'(b - DP_FIRST);
                g = GLYPH_ROM[idx][16:0];
                g[7:0] = g[7:0] | DP_MASK;
            end else begin
                idx = 7'(b - PRINT_FIRST);
                g = GLYPH_ROM[idx][16:0];
            end
            return g;
        endfunction

        function void take_request(logic act, logic [7:0] b);
            display_out_t o;
            o = '0;
            n_accepted++;
            if (act == ACT_TICK) begin
                n_ticks++;
                o.kind = KIND_DRIVE;
                o.digit = 3'(scan);
                if (slot < (1 << bright)) begin
                    o.lit = 1'b1;
                    {o.d1, o.seg_hi, o.seg_lo} = digit_glyph[scan];
                    n_lit++;
                    lit_digits[scan] = 1'b1;
                end
                slot++;
                if (slot >= (1 << BRIGHT_BITS)) begin
                    slot = 0;
                    scan = (scan + 1 >= NUM_DIGITS) ? 0 : scan + 1;
                end
                due_results.push_back(o);
                return;
            end
            if (b >= 8'd1 && b <= BRIGHT_BITS) begin
                bright = 3'(b - 8'd1);
            end else if (b == BYTE_LF || b == BYTE_CR) begin
                write_pos = 0;
            end else if (b >= PRINT_FIRST) begin
                if (write_pos < NUM_DIGITS) begin
                    digit_glyph[write_pos] = glyph_for(b);
                    write_pos++;
                    n_stored++;
                    return;
                end
            end else begin
                n_ignored++;
                return;
            end
            o.kind = KIND_FWD;
            o.fwd = b;
            n_forwarded++;
            due_results.push_back(o);
        endfunction

        function void match_field(string name, logic [7:0] want, logic [7:0] seen);
            if (seen !== want) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void compare_output(logic kind, logic [TDATA_W-1:0] data);
            display_out_t want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual kind %0b data %0h",
                         $time, kind, data);
                errors++;
                return;
            end
            want = due_results.pop_front();
            n_checked++;
            match_field("result_kind", 8'(want.kind), 8'(kind));
            match_field("forward_byte", want.fwd, data[7:0]);
            match_field("digit_lit", 8'(want.lit), 8'(data[8]));
            match_field("digit_index", 8'(want.digit), 8'(data[11:9]));
            match_field("segments_low", want.seg_lo, data[19:12]);
            match_field("segments_high", want.seg_hi, data[27:20]);
            match_field("segment_d1", 8'(want.d1), 8'(data[28]));
            match_field("tdata padding", 8'h00, 8'(data[31:29]));
        endfunction

        function void flag_leftovers();
            foreach (due_results[i]) begin
                $display("%0t: missing result, expected kind %0b data %0h actual none",
                         $time, due_results[i].kind, due_results[i]);
                errors++;
            end
        endfunction
    endclass

endpackage

[sim/tb_top.sv]
// Top-level testbench of the chained sixteen-segment display controller.
`timescale 1ns / 1ps
module tb_top;
    import csd_pkg::*;
    import csd_tb_pkg::*;

    localparam int RANDOM_ITEMS = 630;
    localparam int HOLD_CYCLES  = 60;
    localparam int N_DIRECTED   = 20;

    localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
        {ACT_TICK, 8'h00}, {ACT_BYTE, 8'h00}, {ACT_BYTE, 8'h1F}, {ACT_BYTE, 8'h07},
        {ACT_BYTE, 8'h01}, {ACT_BYTE, 8'h20}, {ACT_BYTE, 8'h7F}, {ACT_BYTE, 8'h80},
        {ACT_BYTE, 8'h9F}, {ACT_BYTE, 8'hA0}, {ACT_BYTE, 8'hFF}, {ACT_BYTE, 8'h41},
        {ACT_BYTE, BYTE_CR}, {ACT_BYTE, 8'hFF}, {ACT_BYTE, BYTE_LF}, {ACT_TICK, 8'hFF},
        {ACT_TICK, 8'h00}, {ACT_BYTE, 8'h06}, {ACT_TICK, 8'h55}, {ACT_BYTE, 8'h1B}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;

    display_drive_model model;
    int burst_left;
    int holds_done;

    chained_sixteen_segment_display_ctrl dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic push_request(input logic act, input logic [7:0] b);
        int gap;
        bit steady;
        steady = (model.n_accepted >= 140 && model.n_accepted < 260) ||
                 (model.n_accepted >= 420 && model.n_accepted < 540);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0 || steady) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                s_tvalid = 1'b0;
                s_tdata = 8'($urandom_range(0, 255));
                s_tuser = 1'($urandom_range(0, 1));
                @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid = 1'b1;
        s_tuser = act;
        s_tdata = b;
        do @(posedge aclk); while (!s_tready);
        model.take_request(act, b);
        burst_left--;
        @(negedge aclk);
    endtask

    initial begin
        int mode;
        int mode_left;
        int phase;
        int hold_at [2];
        mode = 0;
        mode_left = 0;
        phase = 0;
        holds_done = 0;
        hold_at[0] = 150;
        hold_at[1] = 430;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_done < 2 && model != null && model.n_accepted >= hold_at[holds_done]) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_done++;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            phase++;
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = 1'($urandom_range(0, 1));
                2: m_tready = ($urandom_range(0, 3) == 0);
                default: m_tready = (phase % 3 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            model.compare_output(m_tuser, m_tdata);
        end
    end

    initial begin
        int r;
        logic act;
        logic [7:0] b;
        int waited;
        model = new();
        burst_left = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = ACT_TICK;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            push_request(DIRECTED[i][8], DIRECTED[i][7:0]);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            act = ACT_BYTE;
            if (r < 55) begin
                act = ACT_TICK;
                b = 8'($urandom_range(0, 255));
            end else if (r < 80) begin
                b = 8'($urandom_range(PRINT_FIRST, 255));
            end else if (r < 87) begin
                b = $urandom_range(0, 1) ? BYTE_CR : BYTE_LF;
            end else if (r < 93) begin
                b = 8'($urandom_range(1, BRIGHT_BITS));
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            push_request(act, b);
        end
        s_tvalid = 1'b0;

        waited = 0;
        while (model.due_results.size() > 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        model.flag_leftovers();

        $display("Covered %0d requests: %0d ticks (%0d lit, digit mask %b), %0d bytes stored,",
                 model.n_accepted, model.n_ticks, model.n_lit, model.lit_digits, model.n_stored);
        $display("%0d forwarded, %0d ignored; %0d results checked across %0d receiver hold-offs.",
                 model.n_forwarded, model.n_ignored, model.n_checked, holds_done);
        if (model.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
